/* rtl/core/lvtp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvtp_pkg
// Shared types, constants and the quarter-wave sine table for the LFO
// volume / tremolo / auto-pan block.
// ----------------------------------------------------------------------------
package lvtp_pkg;

    // Sample and gain formats
    localparam int SAMPLE_WIDTH = 24;            // signed Q1.23
    localparam int GAIN_WIDTH   = 16;            // unsigned Q1.15, 32768 = 1.0
    localparam int PHASE_WIDTH  = 32;
    localparam int STEP_WIDTH   = 22;
    localparam int MODE_WIDTH   = 2;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 22;

    localparam logic [GAIN_WIDTH-1:0] ONE_Q15 = 16'd32768;

    // Register reset values
    localparam logic [GAIN_WIDTH-1:0] DEPTH_RESET = ONE_Q15;
    localparam logic [STEP_WIDTH-1:0] STEP_RESET  = 22'd486958;

    // Configuration register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEPTH_GAIN  = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_PHASE_STEP  = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_EFFECT_MODE = 2'd2;

    // Effect modes; the unused code falls back to volume
    typedef enum logic [MODE_WIDTH-1:0] {
        MODE_VOLUME  = 2'd0,
        MODE_TREMOLO = 2'd1,
        MODE_PAN     = 2'd2
    } lvtp_mode_t;

    // Quarter-wave sine table: entries 0..SINE_TABLE_DEPTH
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [GAIN_WIDTH-1:0] sine_table_t [0:SINE_TABLE_DEPTH];

    // Taylor series in Q30, eight terms, rounded to Q15 and clamped
    function automatic sine_table_t build_sine_table();
        sine_table_t        tab;
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        int                 k;
        int                 n;
        for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
            term = x;
            sum  = $signed(x);
            for (n = 1; n <= 7; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                case (n)
                    1:       term = term / 6;
                    2:       term = term / 20;
                    3:       term = term / 42;
                    4:       term = term / 72;
                    5:       term = term / 110;
                    6:       term = term / 156;
                    default: term = term / 210;
                endcase
                if ((n % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            r = (64'(sum) + 64'd16384) >> 15;
            if (r > 64'(ONE_Q15)) begin
                r = 64'(ONE_Q15);
            end
            tab[k] = r[GAIN_WIDTH-1:0];
        end
        return tab;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

    // Channel payloads
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_in;
        logic signed [SAMPLE_WIDTH-1:0] right_in;
    } lvtp_in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_out;
        logic signed [SAMPLE_WIDTH-1:0] right_out;
    } lvtp_out_t;

    // LFO stage to gain stage
    typedef struct packed {
        logic [GAIN_WIDTH-1:0] lfo_a;     // 0.5 + 0.5*sin, Q1.15
        logic [GAIN_WIDTH-1:0] depth;     // saturated depth, Q1.15
        logic [MODE_WIDTH-1:0] mode;
        lvtp_in_t              samples;
    } lvtp_s1_t;

    // Gain stage to lanes
    typedef struct packed {
        logic [GAIN_WIDTH-1:0] gain_l;
        logic [GAIN_WIDTH-1:0] gain_r;
        lvtp_in_t              samples;
    } lvtp_s2_t;

endpackage

/* rtl/core/lfo_volume_tremolo_pan_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfo_volume_tremolo_pan_top
// Sine-LFO volume, tremolo and auto-pan for a stereo sample stream.
//
// Usage:
//   s_* carries one stereo pair (Q1.23) per transfer, m_* returns one gained
//   pair per accepted input, in order. cfg_* writes depth_gain (index 0),
//   phase_step (index 1) and effect_mode (index 2); cfg_ready is always high
//   and writes are meant for when no pair is in flight.
//   From input transfer to m_valid a pair passes the LFO lookup stage, the
//   gain stage (one a*depth multiplier), then the two channel lanes feed the
//   output register. One pair per cycle passes while m_ready is high; each
//   stage holds one pair and frees itself whenever the stage after it moves.
//   The LFO phase is used for the pair and then advances by phase_step.
//   Reset clears the phase to zero, empties all stages and loads the
//   register defaults (depth 1.0, 5 Hz step, volume mode).
//   When m_ready is low the output register holds; the stages behind it
//   keep filling, and s_ready drops once all three hold a pair.
// ----------------------------------------------------------------------------
module lfo_volume_tremolo_pan_top
    import lvtp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  lvtp_in_t                  s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output lvtp_out_t                 m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

    logic [GAIN_WIDTH-1:0]  depth_reg, depth_next;
    logic [STEP_WIDTH-1:0]  step_reg, step_next;
    logic [MODE_WIDTH-1:0]  mode_reg, mode_next;

    logic                   s1_valid, s1_ready;
    lvtp_s1_t               s1_data;
    logic                   s2_valid, s2_ready;
    lvtp_s2_t               s2_data;

    logic signed [SAMPLE_WIDTH-1:0] lane_l, lane_r;
    logic                   out_valid_reg, out_valid_next;
    lvtp_out_t              out_data_reg;
    logic                   out_take;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        depth_next = depth_reg;
        step_next  = step_reg;
        mode_next  = mode_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DEPTH_GAIN:  depth_next = cfg_data[GAIN_WIDTH-1:0];
                CFG_PHASE_STEP:  step_next  = cfg_data[STEP_WIDTH-1:0];
                CFG_EFFECT_MODE: mode_next  = cfg_data[MODE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= DEPTH_RESET;
            step_reg  <= STEP_RESET;
            mode_reg  <= MODE_VOLUME;
        end else begin
            depth_reg <= depth_next;
            step_reg  <= step_next;
            mode_reg  <= mode_next;
        end
    end

    // LFO stage
    lvtp_lfo u_lfo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_data     (s_data),
        .depth_gain  (depth_reg),
        .phase_step  (step_reg),
        .effect_mode (mode_reg),
        .out_valid   (s1_valid),
        .out_ready   (s1_ready),
        .out_data    (s1_data)
    );

    // Gain stage
    lvtp_gain u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Channel lanes
    lvtp_lane u_lane_l (
        .sample (s2_data.samples.left_in),
        .gain   (s2_data.gain_l),
        .result (lane_l)
    );

    lvtp_lane u_lane_r (
        .sample (s2_data.samples.right_in),
        .gain   (s2_data.gain_r),
        .result (lane_r)
    );

    // Merge lanes into the output register
    assign s2_ready = !out_valid_reg || m_ready;
    assign out_take = s2_valid && s2_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_take) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            out_data_reg.left_out  <= lane_l;
            out_data_reg.right_out <= lane_r;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* rtl/core/lvtp_lfo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvtp_lfo
// Phase accumulator and quarter-wave sine lookup; registers a = 0.5+0.5*sin
// together with the saturated depth and the samples of the accepted pair.
// ----------------------------------------------------------------------------
module lvtp_lfo
    import lvtp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lvtp_in_t              in_data,
    input  logic [GAIN_WIDTH-1:0] depth_gain,
    input  logic [STEP_WIDTH-1:0] phase_step,
    input  logic [MODE_WIDTH-1:0] effect_mode,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lvtp_s1_t              out_data
);

    logic [PHASE_WIDTH-1:0]   phase_reg, phase_next;
    logic                     valid_reg, valid_next;
    lvtp_s1_t                 data_reg;
    logic [SINE_IDX_BITS:0]   idx_i;
    logic [SINE_IDX_BITS:0]   idx_j;
    logic [GAIN_WIDTH-1:0]    sine_mag;
    logic [GAIN_WIDTH:0]      a_sum;
    logic [GAIN_WIDTH-1:0]    lfo_a;
    logic [GAIN_WIDTH-1:0]    depth_sat;
    logic                     take;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Quadrant fold: odd quadrants mirror the index, upper half negates
    assign idx_i    = {1'b0, phase_reg[PHASE_WIDTH-3 -: SINE_IDX_BITS]};
    assign idx_j    = (SINE_IDX_BITS+1)'(SINE_TABLE_DEPTH) - idx_i;
    assign sine_mag = phase_reg[PHASE_WIDTH-2] ? SINE_TABLE[idx_j] : SINE_TABLE[idx_i];
    assign a_sum    = phase_reg[PHASE_WIDTH-1]
                    ? ({1'b0, ONE_Q15} - {1'b0, sine_mag})
                    : ({1'b0, ONE_Q15} + {1'b0, sine_mag});
    assign lfo_a    = a_sum[GAIN_WIDTH:1];

    // Depth above unity saturates
    assign depth_sat = (depth_gain > ONE_Q15) ? ONE_Q15 : depth_gain;

    // Phase advances once per accepted pair, after use
    always_comb begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        if (take) begin
            phase_next = phase_reg + PHASE_WIDTH'(phase_step);
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg.lfo_a   <= lfo_a;
            data_reg.depth   <= depth_sat;
            data_reg.mode    <= effect_mode;
            data_reg.samples <= in_data;
        end
    end

endmodule

/* rtl/core/lvtp_gain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvtp_gain
// Forms the tremolo gains b and c from a and depth with one multiplier and
// selects the per-channel gain for the effect mode.
// ----------------------------------------------------------------------------
module lvtp_gain
    import lvtp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  lvtp_s1_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output lvtp_s2_t out_data
);

    logic                      valid_reg, valid_next;
    lvtp_s2_t                  data_reg;
    logic [2*GAIN_WIDTH-1:0]   prod_ad;
    logic [2*GAIN_WIDTH-1:0]   prod_rnd;
    logic [2*GAIN_WIDTH-1:0]   c_work;
    logic [GAIN_WIDTH:0]       dry;
    logic [GAIN_WIDTH:0]       gain_b;
    logic [GAIN_WIDTH:0]       gain_c;
    logic [GAIN_WIDTH-1:0]     gain_l;
    logic [GAIN_WIDTH-1:0]     gain_r;
    logic                      take;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // b = (1-d) + round(a*d); c = (1-d) + round((1-a)*d), reusing a*d
    assign prod_ad  = (2*GAIN_WIDTH)'(in_data.lfo_a) * (2*GAIN_WIDTH)'(in_data.depth);
    assign prod_rnd = prod_ad + 32'd16384;
    assign c_work   = {1'b0, in_data.depth, 15'd0} + 32'd16384 - prod_ad;
    assign dry      = {1'b0, ONE_Q15} - {1'b0, in_data.depth};
    assign gain_b   = dry + prod_rnd[GAIN_WIDTH+15:15];
    assign gain_c   = dry + c_work[GAIN_WIDTH+15:15];

    // Mode select; the unused code acts as volume
    always_comb begin
        unique case (in_data.mode)
            MODE_TREMOLO: begin
                gain_l = gain_b[GAIN_WIDTH-1:0];
                gain_r = gain_b[GAIN_WIDTH-1:0];
            end
            MODE_PAN: begin
                gain_l = gain_b[GAIN_WIDTH-1:0];
                gain_r = gain_c[GAIN_WIDTH-1:0];
            end
            default: begin
                gain_l = in_data.depth;
                gain_r = in_data.depth;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg.gain_l  <= gain_l;
            data_reg.gain_r  <= gain_r;
            data_reg.samples <= in_data.samples;
        end
    end

endmodule

/* rtl/core/lvtp_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvtp_lane
// One channel lane: sample times Q1.15 gain, rounded half up to Q1.23.
// ----------------------------------------------------------------------------
module lvtp_lane
    import lvtp_pkg::*;
(
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic        [GAIN_WIDTH-1:0]   gain,
    output logic signed [SAMPLE_WIDTH-1:0] result
);

    localparam int PROD_WIDTH = SAMPLE_WIDTH + GAIN_WIDTH + 1;

    logic signed [PROD_WIDTH-1:0] prod;
    logic signed [PROD_WIDTH-1:0] prod_rnd;
    logic signed [PROD_WIDTH-1:0] prod_shr;

    // Gain is never above one, so the low bits hold the full result
    assign prod     = PROD_WIDTH'(sample) * PROD_WIDTH'($signed({1'b0, gain}));
    assign prod_rnd = prod + PROD_WIDTH'(16384);
    assign prod_shr = prod_rnd >>> 15;
    assign result   = prod_shr[SAMPLE_WIDTH-1:0];

endmodule
